[sv/rgb565_to_yuv_pixel_assert.svh]
// Assertion macros used by the converter's top-level RTL file.
`ifndef RGB565_TO_YUV_PIXEL_ASSERT_SVH
`define RGB565_TO_YUV_PIXEL_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define R2Y_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: ante |-> cons");

// Next-cycle implication, disabled while reset is asserted.
`define R2Y_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: ante |=> cons");

`endif

[sv/r2y_pkg.sv]
// Types and constants shared by the RGB565 to YUV converter.
package r2y_pkg;

	localparam int unsigned COEFF_W = 24;
	localparam int unsigned PIXEL_W = 16;
	localparam int unsigned CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_Y_COEFFS   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_U_COEFFS   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_V_COEFFS   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BIG_ENDIAN = 3'd3;

	localparam logic [COEFF_W-1:0] Y_COEFFS_RST = 24'h0D4121;
	localparam logic [COEFF_W-1:0] U_COEFFS_RST = 24'h70B6DA;
	localparam logic [COEFF_W-1:0] V_COEFFS_RST = 24'hEEA270;

	localparam int unsigned LUMA_SHIFT    = 7;
	localparam int unsigned CHROMA_SHIFT  = 8;
	localparam int unsigned LUMA_OFFSET   = 16;
	localparam int unsigned CHROMA_OFFSET = 128;

	typedef enum logic {
		KIND_LUMA   = 1'b0,
		KIND_CHROMA = 1'b1
	} chan_kind_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb888_t;

endpackage

[sv/rgb565_to_yuv_pixel.sv]
// RGB565 to YUV pixel converter: config registers, two-stage pipeline and handshake.
// Path: input register, one multiply-add level, then the result register on the outputs.
// Throughput: one pixel per cycle while the output is not stalled.
// A stalled output holds its result while the input register still takes one more item.
// Reset (arst_n low, asynchronous) empties both stages and loads the BT.601 coefficients
// with little-endian byte order.
`include "rgb565_to_yuv_pixel_assert.svh"

module rgb565_to_yuv_pixel import r2y_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COEFF_W-1:0]   cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [PIXEL_W-1:0]   pixel,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [7:0]           luma,
	output logic [7:0]           chroma_blue,
	output logic [7:0]           chroma_red
);

	logic [COEFF_W-1:0] y_coeffs_q, u_coeffs_q, v_coeffs_q;
	logic               big_endian_q;

	logic               valid_s1, valid_s2;
	logic [PIXEL_W-1:0] pixel_s1;
	logic [7:0]         luma_s2, cb_s2, cr_s2;
	logic               adv_s1, adv_s2;
	rgb888_t            rgb;
	logic [7:0]         luma_d, cb_d, cr_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			y_coeffs_q   <= Y_COEFFS_RST;
			u_coeffs_q   <= U_COEFFS_RST;
			v_coeffs_q   <= V_COEFFS_RST;
			big_endian_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_Y_COEFFS:   y_coeffs_q   <= cfg_data;
				REG_U_COEFFS:   u_coeffs_q   <= cfg_data;
				REG_V_COEFFS:   v_coeffs_q   <= cfg_data;
				REG_BIG_ENDIAN: big_endian_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// advance a stage when it is empty or the one after it is empty or draining
	assign adv_s2   = !valid_s2 || !out_stall;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			pixel_s1 <= pixel;
		end
		if (adv_s2 && valid_s1) begin
			luma_s2 <= luma_d;
			cb_s2   <= cb_d;
			cr_s2   <= cr_d;
		end
	end

	r2y_unpack u_unpack (
		.pixel      (pixel_s1),
		.big_endian (big_endian_q),
		.rgb        (rgb)
	);

	r2y_chan u_chan_y (
		.kind   (KIND_LUMA),
		.coeffs (y_coeffs_q),
		.rgb    (rgb),
		.value  (luma_d)
	);

	r2y_chan u_chan_u (
		.kind   (KIND_CHROMA),
		.coeffs (u_coeffs_q),
		.rgb    (rgb),
		.value  (cb_d)
	);

	r2y_chan u_chan_v (
		.kind   (KIND_CHROMA),
		.coeffs (v_coeffs_q),
		.rgb    (rgb),
		.value  (cr_d)
	);

	assign out_valid   = valid_s2;
	assign luma        = luma_s2;
	assign chroma_blue = cb_s2;
	assign chroma_red  = cr_s2;

	`R2Y_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, in_valid && !in_stall, valid_s1)
	`R2Y_ASSERT_NEXT(a_s1_moves_to_s2, clk, arst_n, valid_s1 && adv_s2, valid_s2)
	`R2Y_ASSERT_NOW(a_stall_only_when_full, clk, arst_n, in_stall, valid_s1 && valid_s2 && out_stall)

endmodule

[sv/r2y_unpack.sv]
// Byte swap and RGB565 to RGB888 expansion.
module r2y_unpack import r2y_pkg::*; (
	input  logic [PIXEL_W-1:0] pixel,
	input  logic               big_endian,
	output rgb888_t            rgb
);

	logic [PIXEL_W-1:0] p;

	always_comb begin
		p = big_endian ? {pixel[7:0], pixel[15:8]} : pixel;
		// replicate top bits into the low bits
		rgb.r = {p[15:11], p[15:13]};
		rgb.g = {p[10:5], p[10:9]};
		rgb.b = {p[4:0], p[4:2]};
	end

endmodule

[sv/r2y_chan.sv]
// One output channel: weighted sum, shift, offset and saturation.
module r2y_chan import r2y_pkg::*; (
	input  chan_kind_t         kind,
	input  logic [COEFF_W-1:0] coeffs,
	input  rgb888_t            rgb,
	output logic [7:0]         value
);

	logic signed [7:0]  cr, cg, cb;
	logic signed [16:0] pr, pg, pb;
	logic [15:0]        sum;
	logic [15:0]        biased;

	always_comb begin
		cr = $signed(coeffs[7:0]);
		cg = $signed(coeffs[15:8]);
		cb = $signed(coeffs[23:16]);
		pr = $signed({1'b0, rgb.r}) * cr;
		pg = $signed({1'b0, rgb.g}) * cg;
		pb = $signed({1'b0, rgb.b}) * cb;
		// wrap to 16 bits
		sum = pr[15:0] + pg[15:0] + pb[15:0];
		unique case (kind)
			KIND_LUMA: begin
				biased = (sum >> LUMA_SHIFT) + 16'(LUMA_OFFSET);
			end
			KIND_CHROMA: begin
				biased = 16'($signed(sum) >>> CHROMA_SHIFT) + 16'(CHROMA_OFFSET);
			end
			default: begin
				biased = '0;
			end
		endcase
		// clamp signed 16 bits to 0..255
		if (biased[15]) begin
			value = 8'd0;
		end else if (biased[14:8] != 7'd0) begin
			value = 8'hFF;
		end else begin
			value = biased[7:0];
		end
	end

endmodule

[bench/yuv_result_check.sv]
// Watches the converter's ports, predicts each pixel's YUV bytes and checks every result.
`timescale 1ns / 1ps

module yuv_result_check import r2y_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COEFF_W-1:0]   cfg_data,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic [PIXEL_W-1:0]   pixel,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic [7:0]           luma,
	input  logic [7:0]           chroma_blue,
	input  logic [7:0]           chroma_red,
	output int                   failures,
	output int                   outstanding,
	output int                   results_checked
);

	typedef struct packed {
		logic [PIXEL_W-1:0] pixel;
		logic [7:0]         luma;
		logic [7:0]         cb;
		logic [7:0]         cr;
	} yuv_expect_t;

	logic [COEFF_W-1:0] luma_weights;
	logic [COEFF_W-1:0] cb_weights;
	logic [COEFF_W-1:0] cr_weights;
	logic               swap_bytes;
	yuv_expect_t        expected_yuv[$];

	// Three signed 8-bit lanes times the unsigned channels, wrapped to 16 bits.
	function automatic logic [15:0] dot_coeffs(input logic [COEFF_W-1:0] w, input rgb888_t c);
		int wr, wg, wb, acc;
		wr = $signed(w[7:0]);
		wg = $signed(w[15:8]);
		wb = $signed(w[23:16]);
		acc = int'(c.r) * wr + int'(c.g) * wg + int'(c.b) * wb;
		return acc[15:0];
	endfunction

	function automatic logic [7:0] clamp_u8(input logic [15:0] v);
		if (v[15])
			return 8'd0;
		if (v > 16'd255)
			return 8'd255;
		return v[7:0];
	endfunction

	function automatic yuv_expect_t convert_pixel(input logic [PIXEL_W-1:0] px);
		logic [15:0]        p, ys, us, vs;
		logic signed [15:0] ush, vsh;
		rgb888_t            c;
		yuv_expect_t        e;
		p = swap_bytes ? {px[7:0], px[15:8]} : px;
		// widen each channel by repeating its top bits
		c.r = {p[15:11], p[15:13]};
		c.g = {p[10:5], p[10:9]};
		c.b = {p[4:0], p[4:2]};
		ys = dot_coeffs(luma_weights, c);
		us = dot_coeffs(cb_weights, c);
		vs = dot_coeffs(cr_weights, c);
		ush = $signed(us) >>> CHROMA_SHIFT;
		vsh = $signed(vs) >>> CHROMA_SHIFT;
		e.pixel = px;
		e.luma = clamp_u8((ys >> LUMA_SHIFT) + 16'(LUMA_OFFSET));
		e.cb = clamp_u8(ush + 16'(CHROMA_OFFSET));
		e.cr = clamp_u8(vsh + 16'(CHROMA_OFFSET));
		return e;
	endfunction

	function automatic void flag_mismatch(input string field, input logic [15:0] px,
			input logic [7:0] want, input logic [7:0] got);
		failures++;
		if (failures <= 10)
			$display("%0t: %s mismatch for pixel %04h: expected %02h, got %02h",
				$time, field, px, want, got);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		yuv_expect_t e;
		if (!arst_n) begin
			luma_weights = Y_COEFFS_RST;
			cb_weights = U_COEFFS_RST;
			cr_weights = V_COEFFS_RST;
			swap_bytes = 1'b0;
			expected_yuv.delete();
		end else begin
			if (in_valid && !in_stall)
				expected_yuv.push_back(convert_pixel(pixel));
			if (out_valid && !out_stall) begin
				results_checked++;
				if (expected_yuv.size() == 0) begin
					failures++;
					if (failures <= 10)
						$display("%0t: unexpected result %02h %02h %02h", $time,
							luma, chroma_blue, chroma_red);
				end else begin
					e = expected_yuv.pop_front();
					if (luma !== e.luma)
						flag_mismatch("luma", e.pixel, e.luma, luma);
					if (chroma_blue !== e.cb)
						flag_mismatch("chroma_blue", e.pixel, e.cb, chroma_blue);
					if (chroma_red !== e.cr)
						flag_mismatch("chroma_red", e.pixel, e.cr, chroma_red);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_Y_COEFFS: luma_weights = cfg_data;
					REG_U_COEFFS: cb_weights = cfg_data;
					REG_V_COEFFS: cr_weights = cfg_data;
					REG_BIG_ENDIAN: swap_bytes = cfg_data[0];
					default: ;
				endcase
			end
		end
		outstanding = expected_yuv.size();
	end

endmodule

[bench/testbench.sv]
// Drives pixels and register writes into the RGB565 to YUV converter and reports the verdict.
`timescale 1ns / 1ps

module testbench;
	import r2y_pkg::*;

	localparam int CYCLE_LIMIT      = 200000;
	localparam int RANDOM_PHASES    = 8;
	localparam int PIXELS_PER_PHASE = 100;
	localparam int PRESSURE_PIXELS  = 60;
	localparam int HOLDOFF_CYCLES   = 300;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [COEFF_W-1:0]   cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [PIXEL_W-1:0]   pixel = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [7:0]           luma;
	logic [7:0]           chroma_blue;
	logic [7:0]           chroma_red;

	int failures;
	int outstanding;
	int results_checked;
	int pixels_sent;
	int settings_used = 1;
	int cycle_count;
	int idle_pct;
	int stall_pct;
	bit holdoff_armed;
	bit holdoff_done;
	int holdoff_left;

	rgb565_to_yuv_pixel uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .pixel(pixel),
		.out_valid(out_valid), .out_stall(out_stall),
		.luma(luma), .chroma_blue(chroma_blue), .chroma_red(chroma_red)
	);

	yuv_result_check conv_check (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .pixel(pixel),
		.out_valid(out_valid), .out_stall(out_stall),
		.luma(luma), .chroma_blue(chroma_blue), .chroma_red(chroma_red),
		.failures(failures), .outstanding(outstanding), .results_checked(results_checked)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Output side: random stalls, plus one long hold-off when armed.
	always @(negedge clk) begin
		if (holdoff_armed && !holdoff_done) begin
			holdoff_left = HOLDOFF_CYCLES;
			holdoff_done = 1'b1;
		end
		if (holdoff_left > 0) begin
			holdoff_left--;
			out_stall <= 1'b1;
		end else
			out_stall <= ($urandom_range(99) < stall_pct);
	end

	function automatic logic [PIXEL_W-1:0] corner_pixel(input int k);
		case (k)
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'hF800;
			3: return 16'h07E0;
			4: return 16'h001F;
			5: return 16'h8410;
			6: return 16'h7BEF;
			7: return 16'h00FF;
			8: return 16'hFF00;
			default: return 16'h5AA5;
		endcase
	endfunction

	function automatic logic [PIXEL_W-1:0] random_pixel();
		if ($urandom_range(7) == 0)
			return corner_pixel($urandom_range(9));
		return PIXEL_W'($urandom);
	endfunction

	// Called at a falling edge; returns at the falling edge after the item is taken.
	task automatic send_pixel(input logic [PIXEL_W-1:0] px);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			pixel <= PIXEL_W'($urandom);
			@(negedge clk);
		end
		in_valid <= 1'b1;
		pixel <= px;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
		pixels_sent++;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
	endtask

	// Write all registers, then poke an unused index, which must change nothing.
	task automatic load_config(input logic [COEFF_W-1:0] yw, uw, vw, input logic be);
		cfg_we <= 1'b1;
		cfg_index <= REG_Y_COEFFS;
		cfg_data <= yw;
		@(negedge clk);
		cfg_index <= REG_U_COEFFS;
		cfg_data <= uw;
		@(negedge clk);
		cfg_index <= REG_V_COEFFS;
		cfg_data <= vw;
		@(negedge clk);
		// junk above bit 0 must be dropped
		cfg_index <= REG_BIG_ENDIAN;
		cfg_data <= {23'($urandom), be};
		@(negedge clk);
		cfg_index <= REG_BIG_ENDIAN + CFG_IDX_W'($urandom_range(1, 4));
		cfg_data <= COEFF_W'($urandom);
		@(negedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timed out after %0d cycles with %0d results still due", cycle_count,
			outstanding);
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Coefficients straight out of reset.
		for (int i = 0; i < 10; i++)
			send_pixel(corner_pixel(i));
		wait_idle();
		// Largest positive weights overflow the 16-bit sums; swapped bytes.
		load_config(24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F, 1'b1);
		for (int i = 0; i < 8; i++)
			send_pixel(corner_pixel(i));
		wait_idle();
		// Most negative weights drive the luma sum below zero.
		load_config(24'h808080, 24'h808080, 24'h808080, 1'b0);
		for (int i = 0; i < 6; i++)
			send_pixel(corner_pixel(i));

		for (int k = 0; k < RANDOM_PHASES; k++) begin
			wait_idle();
			case (k % 4)
				0: begin idle_pct = 0; stall_pct <= 0; end
				1: begin idle_pct = 88; stall_pct <= 0; end
				2: begin idle_pct = 0; stall_pct <= 88; end
				default: begin idle_pct = 16; stall_pct <= 16; end
			endcase
			case (k)
				0: load_config(Y_COEFFS_RST, U_COEFFS_RST, V_COEFFS_RST, 1'b0);
				1: load_config(24'h7F7F7F, 24'h808080, 24'h000000, 1'b1);
				2: load_config(24'h808080, 24'h7F7F7F, 24'h7F7F7F, 1'b0);
				3: load_config(Y_COEFFS_RST, U_COEFFS_RST, V_COEFFS_RST, 1'b1);
				default: load_config(COEFF_W'($urandom), COEFF_W'($urandom),
					COEFF_W'($urandom), 1'($urandom));
			endcase
			repeat (PIXELS_PER_PHASE)
				send_pixel(random_pixel());
		end

		// Keep offering pixels while the output is held off, so the pipe fills and backs up.
		wait_idle();
		idle_pct = 0;
		stall_pct <= 0;
		holdoff_armed <= 1'b1;
		repeat (PRESSURE_PIXELS)
			send_pixel(random_pixel());

		wait_idle();
		repeat (10) @(negedge clk);
		$display("Sent %0d pixels over %0d register settings; %0d results compared.",
			pixels_sent, settings_used, results_checked);
		$display("Gap mixes: none, input 88%%, output 88%%, both 16%%, one %0d-cycle hold-off.",
			HOLDOFF_CYCLES);
		if (failures == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

[files.f]
+incdir+sv
sv/r2y_pkg.sv
sv/r2y_unpack.sv
sv/r2y_chan.sv
sv/rgb565_to_yuv_pixel.sv
bench/yuv_result_check.sv
bench/testbench.sv
